// ----- design/otx_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// otx_pkg
// Shared types and constants for the overwrite-oldest transmit FIFO.
// ----------------------------------------------------------------------------
package otx_pkg;

    localparam int DEPTH_DEFAULT = 32;
    localparam int BYTE_W        = 8;
    localparam int FREE_W        = 6;
    localparam int CMD_W         = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_POP   = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef struct packed {
        logic load;
        logic shift;
    } ctrl_t;

endpackage
// ----------------------------------------------------------------------------
`default_nettype wire

// ----- design/otx_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// otx_cell
// One storage cell of the FIFO row: load a new byte, take the neighbor's
// byte on a shift, or hold.
// ----------------------------------------------------------------------------
module otx_cell (
    input  wire logic                      aclk,
    input  wire logic                      load_sel,
    input  wire logic                      shift,
    input  wire logic [otx_pkg::BYTE_W-1:0] load_data,
    input  wire logic [otx_pkg::BYTE_W-1:0] neighbor_data,
    output logic      [otx_pkg::BYTE_W-1:0] data_out
);

    logic [otx_pkg::BYTE_W-1:0] data_reg;
    logic [otx_pkg::BYTE_W-1:0] data_next;

    always_comb begin
        data_next = data_reg;
        if (load_sel) begin
            data_next = load_data;
        end else if (shift) begin
            data_next = neighbor_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire

// ----- design/otx_chain.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// otx_chain
// Row of storage cells, oldest byte at cell zero. A shift moves every byte
// one cell toward the head; the tail cell takes the incoming byte.
// ----------------------------------------------------------------------------
module otx_chain #(
    parameter int DEPTH = otx_pkg::DEPTH_DEFAULT,
    parameter int CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                       aclk,
    input  wire otx_pkg::ctrl_t             ctrl,
    input  wire logic [CNT_W-1:0]           load_index,
    input  wire logic [otx_pkg::BYTE_W-1:0] load_data,
    output logic      [otx_pkg::BYTE_W-1:0] head_data
);

    logic [otx_pkg::BYTE_W-1:0] cell_data [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic                       load_sel;
        logic [otx_pkg::BYTE_W-1:0] neighbor_data;

        assign load_sel = ctrl.load && (load_index == CNT_W'(i));

        if (i == DEPTH - 1) begin : g_tail
            assign neighbor_data = load_data;
        end else begin : g_body
            assign neighbor_data = cell_data[i+1];
        end

        otx_cell u_cell (
            .aclk          (aclk),
            .load_sel      (load_sel),
            .shift         (ctrl.shift),
            .load_data     (load_data),
            .neighbor_data (neighbor_data),
            .data_out      (cell_data[i])
        );
    end

    assign head_data = cell_data[0];

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire

// ----- design/overwrite_oldest_tx_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// overwrite_oldest_tx_fifo
// Byte transmit FIFO that drops its oldest byte when a push finds it full.
// ----------------------------------------------------------------------------
// Input channel (s_): one command word per handshake. s_tuser carries the
// command (push, pop, clear), s_tdata the byte to push.
// Output channel (m_): exactly one result word per command, reporting free
// space, the popped byte and its valid flag, the drop flag and whether
// bytes remain for transmit.
// Result: registered; it is presented in the cycle after the command is accepted.
// Throughput: one command per cycle unless a result waits on m_tready low;
// every cell of the storage row loads, shifts or holds at once, so nothing iterates.
// Reset: the byte count and the output valid flag clear; cell contents and
// result fields are left as they are, and cells are only read after a push has written them.
// Stall: while a result waits on m_tready low, s_tready drops and no new
// command is taken; s_tready returns in the cycle the result is taken.
// ----------------------------------------------------------------------------
module overwrite_oldest_tx_fifo #(
    parameter int DEPTH = otx_pkg::DEPTH_DEFAULT
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata    // [5:0] free_space, [6] tx_valid,
                                        // [14:7] tx_byte, [15] dropped_oldest,
                                        // [16] transmit_enable, [23:17] zero
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int BW    = otx_pkg::BYTE_W;
    localparam int FW    = otx_pkg::FREE_W;

    logic             accept;
    logic             full;
    logic             empty;
    otx_pkg::cmd_t    cmd;
    otx_pkg::ctrl_t   ctrl;
    logic [BW-1:0]    head_data;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] free_wide;
    logic             tx_valid_next;
    logic [BW-1:0]    tx_byte_next;
    logic             dropped_next;

    logic             out_valid_reg;
    logic [FW-1:0]    free_reg;
    logic             tx_valid_reg;
    logic [BW-1:0]    tx_byte_reg;
    logic             dropped_reg;
    logic             tx_enable_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign cmd      = otx_pkg::cmd_t'(s_tuser);
    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);

    always_comb begin
        ctrl          = '0;
        count_next    = count_reg;
        tx_valid_next = 1'b0;
        tx_byte_next  = '0;
        dropped_next  = 1'b0;
        if (accept) begin
            unique case (cmd)
                otx_pkg::CMD_PUSH: begin
                    if (full) begin
                        ctrl.shift   = 1'b1;
                        dropped_next = 1'b1;
                    end else begin
                        ctrl.load  = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                otx_pkg::CMD_POP: begin
                    if (!empty) begin
                        ctrl.shift    = 1'b1;
                        count_next    = count_reg - CNT_W'(1);
                        tx_valid_next = 1'b1;
                        tx_byte_next  = head_data;
                    end
                end
                otx_pkg::CMD_CLEAR: begin
                    count_next = '0;
                end
                default: begin
                end
            endcase
        end
    end

    assign free_wide = CNT_W'(DEPTH) - count_next;

    otx_chain #(
        .DEPTH (DEPTH),
        .CNT_W (CNT_W)
    ) u_chain (
        .aclk       (aclk),
        .ctrl       (ctrl),
        .load_index (count_reg),
        .load_data  (s_tdata),
        .head_data  (head_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            free_reg      <= FW'(free_wide);
            tx_valid_reg  <= tx_valid_next;
            tx_byte_reg   <= tx_byte_next;
            dropped_reg   <= dropped_next;
            tx_enable_reg <= (count_next != '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, tx_enable_reg, dropped_reg, tx_byte_reg, tx_valid_reg, free_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("byte count above depth");

    a_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && cmd == otx_pkg::CMD_POP && empty) |=> (!tx_valid_reg && tx_byte_reg == '0))
        else $error("pop on empty FIFO delivered a byte");

    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && cmd == otx_pkg::CMD_PUSH && full) |=> (dropped_reg && full))
        else $error("push on full FIFO did not drop the oldest byte");

    a_tx_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (tx_enable_reg == !empty))
        else $error("transmit enable disagrees with byte count");

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire
